### rtl/core/msb_first_bit_packer_unit_macros.svh
// Assertion macros for the MSB-first bit packer
`ifndef MSB_FIRST_BIT_PACKER_UNIT_MACROS_SVH
`define MSB_FIRST_BIT_PACKER_UNIT_MACROS_SVH

// condition must hold at every edge out of reset
`define MBP_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define MBP_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

### rtl/core/mbp_pkg.sv
// Shared types and constants of the MSB-first bit packer
package mbp_pkg;

  localparam int BYTE_BITS   = 8;
  localparam int N_BITS_W    = 7;
  localparam int VALUE_W     = 64;
  localparam int FREE_W      = 4;
  localparam int QUEUE_DEPTH = 2;

  localparam logic FUNC_APPEND    = 1'b0;
  localparam logic FUNC_FLUSH     = 1'b1;
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_BAD_LEN = 1'b1;

  typedef enum logic [1:0] {
    CMD_APPEND,
    CMD_FLUSH,
    CMD_ERROR
  } mbp_kind_t;

  typedef struct packed {
    mbp_kind_t             kind;
    logic [N_BITS_W-1:0]   n_bits;
  } mbp_cmd_t;

  typedef struct packed {
    logic                busy;
    logic [FREE_W-1:0]   free_bits;
  } mbp_back_stat_t;

endpackage

### rtl/core/mbp_if.sv
// Word channels of the MSB-first bit packer
interface mbp_in_if;
  import mbp_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 func;
  logic [N_BITS_W-1:0]  n_bits;
  logic [VALUE_W-1:0]   value;
  modport source (output valid, func, n_bits, value, input ready);
  modport sink   (input valid, func, n_bits, value, output ready);
endinterface

interface mbp_out_if;
  import mbp_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [BYTE_BITS-1:0]  out_byte;
  logic                  status;
  logic                  last;
  modport source (output valid, out_byte, status, last, input ready);
  modport sink   (input valid, out_byte, status, last, output ready);
endinterface

### rtl/core/msb_first_bit_packer_unit.sv
// Top level of the MSB-first bit packer
//
// in_ch takes one word per handshake: func selects append (low n_bits of
// value, top bit first) or flush of the pending partial byte. out_ch gives
// one byte per word; last marks the final byte caused by an input word, and
// status flags an append longer than MAX_FIELD_BITS (byte 0, state kept).
// A zero-length append and a flush with nothing pending give no output.
// The front accepts a word whenever the two-entry command queue has room,
// so input is taken while the packer is still emitting. The back retires
// one packing step per cycle while out_ch is not stalled: an append emits
// at most one byte per step and takes at least one step; flush and error
// take one step. The first byte goes from the queue entry to the output
// register before it is offered on out_ch (queue write at the accepting edge).
// A stalled out_ch holds its byte; the back then stops and the queue fills,
// after which in_ch.ready drops. Synchronous reset empties the queue and
// the output register and leaves an empty partial byte.
`include "msb_first_bit_packer_unit_macros.svh"

module msb_first_bit_packer_unit #(
  parameter int MAX_FIELD_BITS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  mbp_in_if.sink      in_ch,
  mbp_out_if.source   out_ch
);
  import mbp_pkg::*;

  localparam int Q_W = $bits(mbp_cmd_t) + MAX_FIELD_BITS;

  logic                        q_push, q_ready, q_valid, q_pop;
  mbp_cmd_t                    push_cmd, pop_cmd;
  logic [MAX_FIELD_BITS-1:0]   push_value, pop_value;
  logic [Q_W-1:0]              pop_data;
  mbp_back_stat_t              back_stat;

  mbp_front #(
    .MAX_FIELD_BITS (MAX_FIELD_BITS)
  ) u_front (
    .in_ch   (in_ch),
    .q_ready (q_ready),
    .q_push  (q_push),
    .q_cmd   (push_cmd),
    .q_value (push_value)
  );

  mbp_queue #(
    .DATA_W (Q_W)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  ({push_cmd, push_value}),
    .push_ready (q_ready),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (pop_data)
  );

  assign pop_cmd   = pop_data[Q_W-1 -: $bits(mbp_cmd_t)];
  assign pop_value = pop_data[MAX_FIELD_BITS-1:0];

  mbp_back #(
    .MAX_FIELD_BITS (MAX_FIELD_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_cmd   (pop_cmd),
    .q_value (pop_value),
    .q_pop   (q_pop),
    .out_ch  (out_ch),
    .stat    (back_stat)
  );

  // back only draws from the queue when a command is waiting
  `MBP_ASSERT_IMPLY(a_pop_has_cmd, q_pop, q_valid, "queue popped while empty")
  // a command in progress keeps the queue head where it is
  `MBP_ASSERT_IMPLY(a_busy_no_pop, back_stat.busy, !q_pop, "queue popped mid-command")
  // partial byte always has between one and eight free positions
  `MBP_ASSERT_ALWAYS(a_free_range, (back_stat.free_bits != '0) && (back_stat.free_bits <= FREE_W'(BYTE_BITS)), "free bit count out of range")
  // a rejection is a lone zero word closing its request
  `MBP_ASSERT_IMPLY(a_err_word, out_ch.valid && (out_ch.status == STATUS_BAD_LEN), (out_ch.out_byte == '0) && out_ch.last, "malformed error word")

endmodule

### rtl/core/mbp_front.sv
// Front end: classifies input words and left-aligns append fields
module mbp_front #(
  parameter int MAX_FIELD_BITS = 64
) (
  mbp_in_if.sink                      in_ch,
  input  logic                        q_ready,
  output logic                        q_push,
  output mbp_pkg::mbp_cmd_t           q_cmd,
  output logic [MAX_FIELD_BITS-1:0]   q_value
);
  import mbp_pkg::*;

  localparam int SH_W = $clog2(MAX_FIELD_BITS + 1);

  logic            bad_len;
  logic            drop;
  logic [SH_W-1:0] shamt;

  always_comb begin
    bad_len = (in_ch.n_bits > N_BITS_W'(MAX_FIELD_BITS));
    drop    = 1'b0;
    q_cmd.n_bits = in_ch.n_bits;
    unique case (in_ch.func)
      FUNC_FLUSH: begin
        q_cmd.kind = CMD_FLUSH;
      end
      default: begin
        if (bad_len) begin
          q_cmd.kind = CMD_ERROR;
        end else begin
          q_cmd.kind = CMD_APPEND;
          // zero-length append has no effect at all
          drop = (in_ch.n_bits == '0);
        end
      end
    endcase
    // first field bit lands in the top bit, zeros below
    shamt   = SH_W'(MAX_FIELD_BITS) - SH_W'(in_ch.n_bits);
    q_value = in_ch.value[MAX_FIELD_BITS-1:0] << shamt;
  end

  assign in_ch.ready = q_ready;
  assign q_push      = in_ch.valid && q_ready && !drop;

endmodule

### rtl/core/mbp_queue.sv
// Two-entry command queue between front and back
module mbp_queue #(
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              push_ready,
  output logic              pop_valid,
  input  logic              pop,
  output logic [DATA_W-1:0] pop_data
);
  import mbp_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [DATA_W-1:0] entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = entry_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### rtl/core/mbp_back.sv
// Back end: packs queued commands into bytes, taking a new command only once the current one is done
module mbp_back #(
  parameter int MAX_FIELD_BITS = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  input  mbp_pkg::mbp_cmd_t           q_cmd,
  input  logic [MAX_FIELD_BITS-1:0]   q_value,
  output logic                        q_pop,
  mbp_out_if.source                   out_ch,
  output mbp_pkg::mbp_back_stat_t     stat
);
  import mbp_pkg::*;

  localparam int W = MAX_FIELD_BITS;

  logic                 busy_r, busy_nxt;
  logic [N_BITS_W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]         v_r, v_nxt;
  logic [BYTE_BITS-1:0] partial_r, partial_nxt;
  logic [FREE_W-1:0]    free_r, free_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [BYTE_BITS-1:0] out_byte_r;
  logic                 out_status_r, out_last_r;

  mbp_kind_t            cur_kind;
  logic [N_BITS_W-1:0]  cur_rem, free_ext, left;
  logic [W-1:0]         cur_v, v_sh;
  logic [BYTE_BITS-1:0] chunk, fill;
  logic                 can_go, step, emit, done;
  logic [BYTE_BITS-1:0] e_byte;
  logic                 e_status, e_last;

  always_comb begin
    // a command still in progress takes precedence over the queue head
    cur_kind = busy_r ? CMD_APPEND : q_cmd.kind;
    cur_rem  = busy_r ? rem_r : q_cmd.n_bits;
    cur_v    = busy_r ? v_r : q_value;
    can_go   = !out_valid_r || out_ch.ready;
    step     = (busy_r || q_valid) && can_go;

    chunk    = cur_v[W-1 -: BYTE_BITS];
    fill     = chunk >> (FREE_W'(BYTE_BITS) - free_r);
    free_ext = N_BITS_W'(free_r);
    left     = cur_rem - free_ext;
    v_sh     = cur_v << free_r;

    rem_nxt     = rem_r;
    v_nxt       = v_r;
    partial_nxt = partial_r;
    free_nxt    = free_r;
    emit        = 1'b0;
    done        = 1'b1;
    e_byte      = '0;
    e_status    = STATUS_OK;
    e_last      = 1'b0;

    if (step) begin
      unique case (cur_kind)
        CMD_APPEND: begin
          if (cur_rem >= free_ext) begin
            emit   = 1'b1;
            e_byte = partial_r | fill;
            if (left < N_BITS_W'(BYTE_BITS)) begin
              // remainder fits in the next partial byte: command ends here
              partial_nxt = v_sh[W-1 -: BYTE_BITS];
              free_nxt    = FREE_W'(BYTE_BITS) - FREE_W'(left);
              e_last      = 1'b1;
            end else begin
              partial_nxt = '0;
              free_nxt    = FREE_W'(BYTE_BITS);
              rem_nxt     = left;
              v_nxt       = v_sh;
              done        = 1'b0;
            end
          end else begin
            partial_nxt = partial_r | fill;
            free_nxt    = free_r - FREE_W'(cur_rem);
          end
        end
        CMD_FLUSH: begin
          if (free_r != FREE_W'(BYTE_BITS)) begin
            emit        = 1'b1;
            e_byte      = partial_r;
            e_last      = 1'b1;
            partial_nxt = '0;
            free_nxt    = FREE_W'(BYTE_BITS);
          end
        end
        CMD_ERROR: begin
          emit     = 1'b1;
          e_status = STATUS_BAD_LEN;
          e_last   = 1'b1;
        end
        default: begin
        end
      endcase
    end

    busy_nxt      = step ? !done : busy_r;
    out_valid_nxt = can_go ? (step && emit) : out_valid_r;
  end

  assign q_pop = step && !busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      partial_r   <= '0;
      free_r      <= FREE_W'(BYTE_BITS);
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      partial_r   <= partial_nxt;
      free_r      <= free_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    v_r   <= v_nxt;
    if (step && emit) begin
      out_byte_r   <= e_byte;
      out_status_r <= e_status;
      out_last_r   <= e_last;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.status   = out_status_r;
  assign out_ch.last     = out_last_r;

  assign stat.busy      = busy_r;
  assign stat.free_bits = free_r;

endmodule

### tb/msb_first_bit_packer_unit_tb.sv
// Testbench for the MSB-first bit packer: directed table, random words, byte-by-byte checks
`timescale 1ns / 100ps

module msb_first_bit_packer_unit_tb;
  import mbp_pkg::*;

  localparam int MAX_FIELD = 64;
  localparam int N_DIR     = 23;
  localparam int N_RAND    = 297;

  typedef struct packed {
    logic [BYTE_BITS-1:0] data;
    logic                 status;
    logic                 last;
  } byte_res_t;

  // typed rows carry their own expectation: exp_cnt copies of exp_byte
  typedef struct packed {
    logic                 typed;
    logic                 func;
    logic [N_BITS_W-1:0]  n_bits;
    logic [VALUE_W-1:0]   value;
    logic [3:0]           exp_cnt;
    logic [BYTE_BITS-1:0] exp_byte;
    logic                 exp_status;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    '{1'b1, FUNC_FLUSH,  7'd0,   64'h0,                   4'd0, 8'h00, STATUS_OK},
    '{1'b1, FUNC_APPEND, 7'd0,   64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 8'h00, STATUS_OK},
    '{1'b1, FUNC_APPEND, 7'd8,   64'h0000_0000_0000_00A5, 4'd1, 8'hA5, STATUS_OK},
    '{1'b1, FUNC_APPEND, 7'd64,  64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 8'hFF, STATUS_OK},
    '{1'b1, FUNC_APPEND, 7'd64,  64'h0,                   4'd8, 8'h00, STATUS_OK},
    '{1'b1, FUNC_APPEND, 7'd65,  64'hFFFF_FFFF_FFFF_FFFF, 4'd1, 8'h00, STATUS_BAD_LEN},
    '{1'b1, FUNC_APPEND, 7'd127, 64'hFFFF_FFFF_FFFF_FFFF, 4'd1, 8'h00, STATUS_BAD_LEN},
    '{1'b0, FUNC_APPEND, 7'd1,   64'h1,                   4'd0, 8'h00, STATUS_OK},
    // upper value bits must be ignored
    '{1'b0, FUNC_APPEND, 7'd3,   64'hFFFF_FFFF_FFFF_FFFA, 4'd0, 8'h00, STATUS_OK},
    // rejected length with bits pending: state must survive
    '{1'b1, FUNC_APPEND, 7'd100, 64'h0123_4567_89AB_CDEF, 4'd1, 8'h00, STATUS_BAD_LEN},
    '{1'b0, FUNC_FLUSH,  7'd127, 64'hDEAD_BEEF_0BAD_F00D, 4'd0, 8'h00, STATUS_OK},
    '{1'b1, FUNC_FLUSH,  7'd64,  64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 8'h00, STATUS_OK},
    '{1'b0, FUNC_APPEND, 7'd7,   64'h55,                  4'd0, 8'h00, STATUS_OK},
    '{1'b0, FUNC_APPEND, 7'd64,  64'h0123_4567_89AB_CDEF, 4'd0, 8'h00, STATUS_OK},
    '{1'b0, FUNC_FLUSH,  7'd0,   64'h0,                   4'd0, 8'h00, STATUS_OK},
    '{1'b0, FUNC_APPEND, 7'd1,   64'h0,                   4'd0, 8'h00, STATUS_OK},
    '{1'b0, FUNC_APPEND, 7'd63,  64'h7FFF_FFFF_FFFF_FFFF, 4'd0, 8'h00, STATUS_OK},
    '{1'b0, FUNC_APPEND, 7'd64,  64'h8000_0000_0000_0001, 4'd0, 8'h00, STATUS_OK},
    '{1'b1, FUNC_APPEND, 7'd0,   64'h0,                   4'd0, 8'h00, STATUS_OK},
    '{1'b0, FUNC_FLUSH,  7'd5,   64'h1F,                  4'd0, 8'h00, STATUS_OK},
    '{1'b0, FUNC_APPEND, 7'd4,   64'hF,                   4'd0, 8'h00, STATUS_OK},
    '{1'b0, FUNC_FLUSH,  7'd0,   64'h0,                   4'd0, 8'h00, STATUS_OK},
    '{1'b1, FUNC_FLUSH,  7'd0,   64'h0,                   4'd0, 8'h00, STATUS_OK}
  };

  logic clk;
  logic rst_n;

  mbp_in_if  in_ch_if ();
  mbp_out_if out_ch_if ();

  msb_first_bit_packer_unit #(
    .MAX_FIELD_BITS(MAX_FIELD)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch_if),
    .out_ch(out_ch_if)
  );

  // packer state as the block should hold it
  logic [BYTE_BITS-1:0] pend_byte;
  logic [FREE_W-1:0]    pend_free;
  byte_res_t            packed_q[$];
  byte_res_t            byte_exp_q[$];

  int err_cnt;
  int word_cnt;
  int flush_cnt;
  int bad_len_cnt;
  int byte_cnt;

  int burst_left;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // bytes this word should produce, into packed_q
  function automatic void pack_word(input logic f, input logic [N_BITS_W-1:0] n,
                                    input logic [VALUE_W-1:0] v);
    int k;
    packed_q.delete();
    if (pend_free < 1 || pend_free > BYTE_BITS) begin
      pend_free = FREE_W'(BYTE_BITS);
      pend_byte = '0;
    end
    if (f == FUNC_FLUSH) begin
      if (pend_free != BYTE_BITS) begin
        packed_q.push_back('{pend_byte, STATUS_OK, 1'b0});
        pend_byte = '0;
        pend_free = FREE_W'(BYTE_BITS);
      end
    end else if (n > MAX_FIELD) begin
      packed_q.push_back('{8'h00, STATUS_BAD_LEN, 1'b0});
    end else begin
      for (k = int'(n); k > 0; k--) begin
        pend_free = pend_free - 1'b1;
        pend_byte[pend_free[2:0]] = v[k-1];
        if (pend_free == 0) begin
          if (packed_q.size() < 8) packed_q.push_back('{pend_byte, STATUS_OK, 1'b0});
          pend_byte = '0;
          pend_free = FREE_W'(BYTE_BITS);
        end
      end
    end
    if (packed_q.size() > 0) packed_q[packed_q.size()-1].last = 1'b1;
  endfunction

  // start of a burst: maybe drop valid for a while, with junk on the payload
  task automatic pause_between_bursts();
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 8);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      if (gap > 0) begin
        in_ch_if.valid  <= 1'b0;
        in_ch_if.func   <= 1'($urandom_range(0, 1));
        in_ch_if.n_bits <= N_BITS_W'($urandom_range(0, 127));
        in_ch_if.value  <= {$urandom, $urandom};
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  // offer one word and wait for the handshake; predicted bytes queued if asked
  task automatic offer_word(input logic f, input logic [N_BITS_W-1:0] n,
                            input logic [VALUE_W-1:0] v, input bit use_pred);
    pause_between_bursts();
    in_ch_if.valid  <= 1'b1;
    in_ch_if.func   <= f;
    in_ch_if.n_bits <= n;
    in_ch_if.value  <= v;
    do @(posedge clk); while (!in_ch_if.ready);
    word_cnt++;
    if (f == FUNC_FLUSH) flush_cnt++;
    else if (n > MAX_FIELD) bad_len_cnt++;
    pack_word(f, n, v);
    if (use_pred) begin
      foreach (packed_q[i]) byte_exp_q.push_back(packed_q[i]);
    end
  endtask

  initial begin : stimulus
    logic                f;
    logic [N_BITS_W-1:0] n;
    logic [VALUE_W-1:0]  v;
    int                  r;
    rst_n           = 1'b0;
    in_ch_if.valid  = 1'b0;
    in_ch_if.func   = FUNC_APPEND;
    in_ch_if.n_bits = '0;
    in_ch_if.value  = '0;
    pend_byte       = '0;
    pend_free       = FREE_W'(BYTE_BITS);
    err_cnt         = 0;
    word_cnt        = 0;
    flush_cnt       = 0;
    bad_len_cnt     = 0;
    byte_cnt        = 0;
    burst_left      = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIR; i++) begin
      offer_word(DIR_ROWS[i].func, DIR_ROWS[i].n_bits, DIR_ROWS[i].value, !DIR_ROWS[i].typed);
      if (DIR_ROWS[i].typed) begin
        for (int j = 0; j < DIR_ROWS[i].exp_cnt; j++)
          byte_exp_q.push_back('{DIR_ROWS[i].exp_byte, DIR_ROWS[i].exp_status,
                                 j == DIR_ROWS[i].exp_cnt - 1});
      end
    end

    for (int i = 0; i < N_RAND; i++) begin
      f = ($urandom_range(0, 99) < 15) ? FUNC_FLUSH : FUNC_APPEND;
      r = $urandom_range(0, 99);
      if (r < 8)       n = N_BITS_W'($urandom_range(MAX_FIELD + 1, 127));
      else if (r < 12) n = '0;
      else if (r < 22) n = N_BITS_W'(MAX_FIELD);
      else             n = N_BITS_W'($urandom_range(1, MAX_FIELD));
      v = {$urandom, $urandom};
      offer_word(f, n, v, 1'b1);
    end
    in_ch_if.valid <= 1'b0;

    while (byte_exp_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Ran %0d words (%0d flushes, %0d rejected lengths); %0d bytes checked.",
             word_cnt, flush_cnt, bad_len_cnt, byte_cnt);
    $display("Receiver stalls included two long hold-offs that backed up the input.");
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // receiver: random segments of steady, light and heavy stalling, plus long hold-offs
  initial begin : rx_pattern
    int cyc;
    int seg_left;
    int mode;
    cyc      = 0;
    seg_left = 0;
    mode     = 0;
    out_ch_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (seg_left == 0) begin
        seg_left = $urandom_range(4, 40);
        mode     = $urandom_range(0, 2);
      end
      seg_left--;
      if ((cyc >= 300 && cyc < 450) || (cyc >= 1000 && cyc < 1160)) begin
        out_ch_if.ready <= 1'b0;
      end else begin
        case (mode)
          0: begin
            out_ch_if.ready <= 1'b1;
          end
          1: begin
            out_ch_if.ready <= ($urandom_range(0, 9) < 7);
          end
          default: begin
            out_ch_if.ready <= ($urandom_range(0, 9) < 3);
          end
        endcase
      end
    end
  end

  always @(posedge clk) begin : byte_check
    byte_res_t want;
    if (rst_n && out_ch_if.valid && out_ch_if.ready) begin
      if (byte_exp_q.size() == 0) begin
        $error("unexpected word: out_byte %0h status %0b last %0b",
               out_ch_if.out_byte, out_ch_if.status, out_ch_if.last);
        err_cnt++;
      end else begin
        want = byte_exp_q.pop_front();
        byte_cnt++;
        if (out_ch_if.out_byte !== want.data) begin
          $error("out_byte: expected %0h, actual %0h", want.data, out_ch_if.out_byte);
          err_cnt++;
        end
        if (out_ch_if.status !== want.status) begin
          $error("status: expected %0b, actual %0b", want.status, out_ch_if.status);
          err_cnt++;
        end
        if (out_ch_if.last !== want.last) begin
          $error("last: expected %0b, actual %0b", want.last, out_ch_if.last);
          err_cnt++;
        end
      end
    end
  end

  initial begin : watchdog
    #4_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

### msb_first_bit_packer_unit.f
+incdir+rtl/core
rtl/core/mbp_pkg.sv
rtl/core/mbp_if.sv
rtl/core/mbp_front.sv
rtl/core/mbp_queue.sv
rtl/core/mbp_back.sv
rtl/core/msb_first_bit_packer_unit.sv
tb/msb_first_bit_packer_unit_tb.sv
